[sv/ring_buffer_deque_macros.svh]
// ----------------------------------------------------------------------------
// ring_buffer_deque_macros
// assertion helpers for the deque rtl
// ----------------------------------------------------------------------------
`ifndef RING_BUFFER_DEQUE_MACROS_SVH
`define RING_BUFFER_DEQUE_MACROS_SVH

// same-cycle implication
`define RBD_ASSERT_IMPL(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("ring_buffer_deque check failed");

// next-cycle implication
`define RBD_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("ring_buffer_deque check failed");

`endif

[sv/rbd_pkg.sv]
// ----------------------------------------------------------------------------
// rbd_pkg
// shared constants and types of the ring buffer deque
// ----------------------------------------------------------------------------
package rbd_pkg;

  localparam int DEPTH  = 16;
  localparam int DATA_W = 32;
  localparam int IDX_W  = $clog2(DEPTH);
  localparam int CNT_W  = $clog2(DEPTH + 1);
  localparam int POS_W  = 8;
  localparam int CMP_W  = (CNT_W > POS_W) ? CNT_W : POS_W;

  localparam logic [2:0] CMD_PUSH_BACK  = 3'd0;
  localparam logic [2:0] CMD_PUSH_FRONT = 3'd1;
  localparam logic [2:0] CMD_POP_BACK   = 3'd2;
  localparam logic [2:0] CMD_POP_FRONT  = 3'd3;
  localparam logic [2:0] CMD_READ       = 3'd4;

  localparam logic [1:0] ST_OK    = 2'd0;
  localparam logic [1:0] ST_FULL  = 2'd1;
  localparam logic [1:0] ST_EMPTY = 2'd2;
  localparam logic [1:0] ST_RANGE = 2'd3;

  typedef enum logic [1:0] {
    CELL_HOLD,
    CELL_TAKE_LEFT,
    CELL_TAKE_RIGHT,
    CELL_LOAD
  } cell_op_t;

  typedef struct packed {
    cell_op_t                  op;
    logic signed [DATA_W-1:0]  load_word;
  } rbd_cell_ctrl_t;

endpackage

[sv/ring_buffer_deque.sv]
// ----------------------------------------------------------------------------
// ring_buffer_deque
// double-ended queue of signed 32-bit words in a row of shifting cells
// ----------------------------------------------------------------------------
// usage:
//   in_valid/in_stall carry one request (in_cmd, in_value, in_pos): push back,
//   push front, pop back, pop front or read at a position from the front.
//   every request gives exactly one response on out_valid/out_stall with
//   out_read_data, out_count (entries after the request) and out_status.
//   cell k always holds the entry at position k; a push front or pop front
//   shifts the whole row by one cell, a push back loads the cell at the count
//   and a pop back only drops the count.
//   the response is registered and appears in the cycle after the request is taken.
//   throughput: one request per cycle while in_stall is low, set by the registered cell update.
//   while the receiver stalls a waiting response, in_stall is raised and the
//   response holds; no request is taken until it leaves.
//   reset empties the deque (count zero) and drops any waiting response;
//   cell contents are not cleared and are never read before written.
// ----------------------------------------------------------------------------
`include "ring_buffer_deque_macros.svh"

module ring_buffer_deque (
  input  logic                                clk,
  input  logic                                rst_n,
  input  logic                                in_valid,
  output logic                                in_stall,
  input  logic [2:0]                          in_cmd,
  input  logic signed [rbd_pkg::DATA_W-1:0]   in_value,
  input  logic [rbd_pkg::POS_W-1:0]           in_pos,
  output logic                                out_valid,
  input  logic                                out_stall,
  output logic signed [rbd_pkg::DATA_W-1:0]   out_read_data,
  output logic [4:0]                          out_count,
  output logic [1:0]                          out_status
);
  import rbd_pkg::*;

  logic                     acc;
  logic                     full;
  logic                     empty;
  logic [IDX_W-1:0]         rd_idx;
  logic                     in_range;
  logic                     push_ok;
  logic                     full_resp;
  logic                     err_resp;

  logic [CNT_W-1:0]         occ_r;
  logic [CNT_W-1:0]         occ_nxt;
  logic                     out_valid_r;
  logic                     out_valid_nxt;
  logic signed [DATA_W-1:0] out_data_r;
  logic signed [DATA_W-1:0] out_data_nxt;
  logic [4:0]               out_count_r;
  logic [4:0]               out_count_nxt;
  logic [1:0]               out_status_r;
  logic [1:0]               out_status_nxt;

  rbd_cell_ctrl_t           cell_ctrl [DEPTH];
  logic signed [DATA_W-1:0] cell_q    [DEPTH];
  logic signed [DATA_W-1:0] left_d    [DEPTH];
  logic signed [DATA_W-1:0] right_d   [DEPTH];

  assign in_stall = out_valid_r && out_stall;
  assign acc      = in_valid && !in_stall;
  assign full     = (occ_r == CNT_W'(DEPTH));
  assign empty    = (occ_r == '0);
  assign rd_idx   = IDX_W'(in_pos);
  assign in_range = (CMP_W'(in_pos) < CMP_W'(occ_r));

  always_comb begin
    cell_op_t op_all;
    logic     load_back;
    op_all         = CELL_HOLD;
    load_back      = 1'b0;
    occ_nxt        = occ_r;
    out_data_nxt   = '0;
    out_status_nxt = ST_OK;
    if (acc) begin
      unique case (in_cmd)
        CMD_PUSH_BACK: begin
          if (full) begin
            out_status_nxt = ST_FULL;
          end else begin
            load_back = 1'b1;
            occ_nxt   = occ_r + 1'b1;
          end
        end
        CMD_PUSH_FRONT: begin
          if (full) begin
            out_status_nxt = ST_FULL;
          end else begin
            op_all  = CELL_TAKE_LEFT;
            occ_nxt = occ_r + 1'b1;
          end
        end
        CMD_POP_BACK: begin
          if (empty) begin
            out_status_nxt = ST_EMPTY;
          end else begin
            occ_nxt = occ_r - 1'b1;
          end
        end
        CMD_POP_FRONT: begin
          if (empty) begin
            out_status_nxt = ST_EMPTY;
          end else begin
            op_all  = CELL_TAKE_RIGHT;
            occ_nxt = occ_r - 1'b1;
          end
        end
        CMD_READ: begin
          if (in_range) begin
            out_data_nxt = cell_q[rd_idx];
          end else begin
            out_status_nxt = ST_RANGE;
          end
        end
        default: begin
        end
      endcase
    end
    out_count_nxt = 5'(occ_nxt);
    for (int i = 0; i < DEPTH; i++) begin
      cell_ctrl[IDX_W'(i)].load_word = in_value;
      if (load_back && (occ_r == CNT_W'(i))) begin
        cell_ctrl[IDX_W'(i)].op = CELL_LOAD;
      end else begin
        cell_ctrl[IDX_W'(i)].op = op_all;
      end
    end
  end

  always_comb begin
    if (acc) begin
      out_valid_nxt = 1'b1;
    end else if (out_stall) begin
      out_valid_nxt = out_valid_r;
    end else begin
      out_valid_nxt = 1'b0;
    end
  end

  for (genvar g = 0; g < DEPTH; g++) begin : g_cell
    if (g == 0) begin : g_first
      assign left_d[g] = in_value;
    end else begin : g_mid_l
      assign left_d[g] = cell_q[g-1];
    end
    if (g == DEPTH - 1) begin : g_last
      assign right_d[g] = cell_q[g];
    end else begin : g_mid_r
      assign right_d[g] = cell_q[g+1];
    end
    rbd_cell u_cell (
      .clk     (clk),
      .ctrl    (cell_ctrl[g]),
      .left_d  (left_d[g]),
      .right_d (right_d[g]),
      .q       (cell_q[g])
    );
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      occ_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      occ_r       <= occ_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (acc) begin
      out_data_r   <= out_data_nxt;
      out_count_r  <= out_count_nxt;
      out_status_r <= out_status_nxt;
    end
  end

  assign out_valid     = out_valid_r;
  assign out_read_data = out_data_r;
  assign out_count     = out_count_r;
  assign out_status    = out_status_r;

  // checker terms
  assign push_ok   = acc && !full && (in_cmd == CMD_PUSH_BACK || in_cmd == CMD_PUSH_FRONT);
  assign full_resp = out_valid_r && (out_status_r == ST_FULL);
  assign err_resp  = out_valid_r && (out_status_r != ST_OK);

  `RBD_ASSERT_IMPL(a_occ_bound, clk, rst_n, 1'b1, occ_r <= CNT_W'(DEPTH))
  `RBD_ASSERT_IMPL(a_full_count, clk, rst_n, full_resp, out_count_r == 5'(DEPTH))
  `RBD_ASSERT_IMPL(a_err_zero, clk, rst_n, err_resp, out_data_r == '0)
  `RBD_ASSERT_NEXT(a_push_grows, clk, rst_n, push_ok, occ_r == $past(occ_r) + 1'b1)
  `RBD_ASSERT_NEXT(a_stall_holds, clk, rst_n, in_stall,
                   out_valid && $stable(out_status) && $stable(occ_r))

endmodule

[sv/rbd_cell.sv]
// ----------------------------------------------------------------------------
// rbd_cell
// one slot of the deque, holds or takes a word from a neighbor or the request
// ----------------------------------------------------------------------------
module rbd_cell (
  input  logic                                clk,
  input  rbd_pkg::rbd_cell_ctrl_t             ctrl,
  input  logic signed [rbd_pkg::DATA_W-1:0]   left_d,
  input  logic signed [rbd_pkg::DATA_W-1:0]   right_d,
  output logic signed [rbd_pkg::DATA_W-1:0]   q
);
  import rbd_pkg::*;

  logic signed [DATA_W-1:0] data_r;
  logic signed [DATA_W-1:0] data_nxt;

  always_comb begin
    unique case (ctrl.op)
      CELL_HOLD:       data_nxt = data_r;
      CELL_TAKE_LEFT:  data_nxt = left_d;
      CELL_TAKE_RIGHT: data_nxt = right_d;
      CELL_LOAD:       data_nxt = ctrl.load_word;
      default:         data_nxt = data_r;
    endcase
  end

  always_ff @(posedge clk) begin
    data_r <= data_nxt;
  end

  assign q = data_r;

endmodule

[verif/ring_buffer_deque_test.sv]
// ----------------------------------------------------------------------------
// ring_buffer_deque_test
// self-checking bench: directed corners, then random fill and drain bursts
// ----------------------------------------------------------------------------
module ring_buffer_deque_test;
  timeunit 1ns;
  timeprecision 1ps;

  import rbd_pkg::*;

  localparam int RANDOM_REQS = 1950;
  localparam int CYCLE_LIMIT = 400000;
  localparam int DRAIN_WAIT  = 6;

  typedef struct packed {
    logic [2:0]               cmd;
    logic signed [DATA_W-1:0] value;
    logic [POS_W-1:0]         pos;
  } deque_req_t;

  typedef struct packed {
    logic signed [DATA_W-1:0] read_data;
    logic [4:0]               count;
    logic [1:0]               status;
  } deque_resp_t;

  logic                     clk = 1'b0;
  logic                     rst_n = 1'b0;
  logic                     in_valid = 1'b0;
  logic                     in_stall;
  logic [2:0]               in_cmd = '0;
  logic signed [DATA_W-1:0] in_value = '0;
  logic [POS_W-1:0]         in_pos = '0;
  logic                     out_valid;
  logic                     out_stall = 1'b0;
  logic signed [DATA_W-1:0] out_read_data;
  logic [4:0]               out_count;
  logic [1:0]               out_status;

  deque_req_t  pending_reqs[$];
  deque_resp_t expected_resps[$];

  // behavioral deque
  logic signed [DATA_W-1:0] slot_mem [DEPTH];
  int                       front_idx;
  int                       back_idx;
  int                       held;

  int  gen_fill;
  int  accepted_reqs = 0;
  int  cycle_count = 0;
  int  send_idle_pct;
  int  recv_stall_pct;
  bit  req_taken = 1'b0;
  bit  failed = 1'b0;

  ring_buffer_deque dut (
    .clk          (clk),
    .rst_n        (rst_n),
    .in_valid     (in_valid),
    .in_stall     (in_stall),
    .in_cmd       (in_cmd),
    .in_value     (in_value),
    .in_pos       (in_pos),
    .out_valid    (out_valid),
    .out_stall    (out_stall),
    .out_read_data(out_read_data),
    .out_count    (out_count),
    .out_status   (out_status)
  );

  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  task automatic deque_apply(input deque_req_t r, output deque_resp_t e);
    e.read_data = '0;
    e.status    = ST_OK;
    case (r.cmd)
      CMD_PUSH_BACK: begin
        if (held >= DEPTH) begin
          e.status = ST_FULL;
        end else begin
          slot_mem[IDX_W'(back_idx)] = r.value;
          back_idx = (back_idx + 1) % DEPTH;
          held++;
        end
      end
      CMD_PUSH_FRONT: begin
        if (held >= DEPTH) begin
          e.status = ST_FULL;
        end else begin
          front_idx = (front_idx + DEPTH - 1) % DEPTH;
          slot_mem[IDX_W'(front_idx)] = r.value;
          held++;
        end
      end
      CMD_POP_BACK: begin
        if (held == 0) begin
          e.status = ST_EMPTY;
        end else begin
          back_idx = (back_idx + DEPTH - 1) % DEPTH;
          held--;
        end
      end
      CMD_POP_FRONT: begin
        if (held == 0) begin
          e.status = ST_EMPTY;
        end else begin
          front_idx = (front_idx + 1) % DEPTH;
          held--;
        end
      end
      CMD_READ: begin
        if (int'(r.pos) >= held) begin
          e.status = ST_RANGE;
        end else begin
          e.read_data = slot_mem[IDX_W'((front_idx + int'(r.pos)) % DEPTH)];
        end
      end
      default: ;
    endcase
    e.count = 5'(held);
  endtask

  task automatic add_req(input logic [2:0] c, input logic signed [DATA_W-1:0] v,
                         input logic [POS_W-1:0] p);
    deque_req_t r;
    r.cmd   = c;
    r.value = v;
    r.pos   = p;
    pending_reqs.push_back(r);
    if ((c == CMD_PUSH_BACK || c == CMD_PUSH_FRONT) && gen_fill < DEPTH) begin
      gen_fill++;
    end else if ((c == CMD_POP_BACK || c == CMD_POP_FRONT) && gen_fill > 0) begin
      gen_fill--;
    end
  endtask

  function automatic logic signed [DATA_W-1:0] pick_word();
    int sel;
    sel = $urandom_range(0, 9);
    if (sel == 0) begin
      return 32'sh8000_0000;
    end else if (sel == 1) begin
      return 32'sh7fff_ffff;
    end else if (sel == 2) begin
      return -32'sd1;
    end
    return $urandom;
  endfunction

  always_comb begin
    if (accepted_reqs < 700) begin
      send_idle_pct  = 14;
      recv_stall_pct = 58;
    end else if (accepted_reqs < 1400) begin
      send_idle_pct  = 58;
      recv_stall_pct = 14;
    end else begin
      send_idle_pct  = 0;
      recv_stall_pct = 0;
    end
  end

  always @(negedge clk) begin : drive
    deque_req_t nxt;
    if (!rst_n) begin
      in_valid <= 1'b0;
    end else if (in_valid && !req_taken) begin
      in_valid <= 1'b1;
    end else if (pending_reqs.size() != 0 && $urandom_range(0, 99) >= send_idle_pct) begin
      nxt = pending_reqs.pop_front();
      in_valid <= 1'b1;
      in_cmd   <= nxt.cmd;
      in_value <= nxt.value;
      in_pos   <= nxt.pos;
    end else begin
      in_valid <= 1'b0;
    end
  end

  always @(negedge clk) begin
    out_stall <= rst_n && ($urandom_range(0, 99) < recv_stall_pct);
  end

  always @(posedge clk) begin : watch
    deque_resp_t want;
    deque_resp_t got;
    deque_req_t  req;
    if (!rst_n) begin
      front_idx = 0;
      back_idx  = 0;
      held      = 0;
      expected_resps.delete();
      req_taken <= 1'b0;
    end else begin
      if (out_valid && !out_stall) begin
        got.read_data = out_read_data;
        got.count     = out_count;
        got.status    = out_status;
        if (expected_resps.size() == 0) begin
          $error("response with none expected: read_data %0d count %0d status %0d",
                 got.read_data, got.count, got.status);
          failed = 1'b1;
        end else begin
          want = expected_resps.pop_front();
          if (got.read_data !== want.read_data) begin
            $error("read_data mismatch: expected %0d, actual %0d",
                   want.read_data, got.read_data);
            failed = 1'b1;
          end
          if (got.count !== want.count) begin
            $error("count mismatch: expected %0d, actual %0d", want.count, got.count);
            failed = 1'b1;
          end
          if (got.status !== want.status) begin
            $error("status mismatch: expected %0d, actual %0d", want.status, got.status);
            failed = 1'b1;
          end
        end
      end
      req_taken <= in_valid && !in_stall;
      if (in_valid && !in_stall) begin
        req.cmd   = in_cmd;
        req.value = in_value;
        req.pos   = in_pos;
        deque_apply(req, want);
        expected_resps.push_back(want);
        accepted_reqs++;
      end
    end
  end

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == CYCLE_LIMIT) begin
      $display("FAIL ring_buffer_deque");
      $finish;
    end
  end

  initial begin : stimulus
    int   real_reqs;
    int   target;
    int   burst;
    int   roll;
    bit   grow;
    logic [2:0] c;
    gen_fill = 0;

    // empty deque corner cases and unused codes
    add_req(CMD_POP_BACK, 32'sd0, 8'd0);
    add_req(CMD_POP_FRONT, 32'sd0, 8'd0);
    add_req(CMD_READ, 32'sd0, 8'd255);
    add_req(3'd5, 32'sh7fff_ffff, 8'd255);
    add_req(3'd7, 32'sh8000_0000, 8'd0);
    // fill from both ends, wrapping the front pointer
    for (int i = 0; i < DEPTH; i++) begin
      add_req((i % 2 == 0) ? CMD_PUSH_BACK : CMD_PUSH_FRONT,
              (i == 0) ? 32'sh8000_0000 : (i == 1) ? 32'sh7fff_ffff :
              (i == 2) ? -32'sd1 : (i == 3) ? 32'sd0 : $urandom, 8'd0);
    end
    add_req(CMD_PUSH_BACK, 32'sd1, 8'd0);
    add_req(CMD_PUSH_FRONT, 32'sd2, 8'd0);
    add_req(CMD_READ, 32'sd0, 8'(DEPTH - 1));
    add_req(CMD_READ, 32'sd0, 8'(DEPTH));
    add_req(CMD_POP_FRONT, 32'sd0, 8'd0);
    add_req(CMD_POP_BACK, 32'sd0, 8'd0);

    // fill and drain bursts toward random levels
    real_reqs = 0;
    while (real_reqs < RANDOM_REQS) begin
      if ($urandom_range(0, 3) == 0) begin
        target = $urandom_range(0, 1) ? DEPTH : 0;
      end else begin
        target = $urandom_range(0, DEPTH);
      end
      burst = $urandom_range(8, 40);
      repeat (burst) begin
        roll = $urandom_range(0, 99);
        if (roll < 2) begin
          add_req(3'($urandom_range(5, 7)), pick_word(), 8'($urandom));
        end else begin
          if (roll < 30) begin
            c = CMD_READ;
          end else begin
            if (gen_fill < target) begin
              grow = 1'b1;
            end else if (gen_fill > target) begin
              grow = 1'b0;
            end else begin
              grow = 1'($urandom_range(0, 1));
            end
            if ($urandom_range(0, 99) < 15) begin
              grow = !grow;
            end
            if (grow) begin
              c = $urandom_range(0, 1) ? CMD_PUSH_BACK : CMD_PUSH_FRONT;
            end else begin
              c = $urandom_range(0, 1) ? CMD_POP_BACK : CMD_POP_FRONT;
            end
          end
          add_req(c, pick_word(),
                  ($urandom_range(0, 7) == 0) ? 8'($urandom) : 8'($urandom_range(0, gen_fill)));
          real_reqs++;
        end
      end
    end

    repeat (7) @(negedge clk);
    rst_n <= 1'b1;

    while (pending_reqs.size() != 0 || in_valid) begin
      @(posedge clk);
    end
    while (expected_resps.size() != 0) begin
      @(posedge clk);
    end
    repeat (DRAIN_WAIT) @(posedge clk);
    if (!failed && expected_resps.size() == 0) begin
      $display("PASS ring_buffer_deque");
    end else begin
      $display("FAIL ring_buffer_deque");
    end
    $finish;
  end

endmodule

[filelist.f]
+incdir+sv
sv/rbd_pkg.sv
sv/rbd_cell.sv
sv/ring_buffer_deque.sv
verif/ring_buffer_deque_test.sv
